### hw/rtl/prcd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the packed run-length capture decoder.
// No dependencies; used by every module of the block.
package prcd_pkg;

    localparam int SLICE_WORDS      = 8;
    localparam int XFER_W           = 32;
    localparam int WORD_W           = 36;
    localparam int NUM_CH           = 34;
    localparam int RUN_W            = 38;
    localparam int LIMIT_W          = 40;
    localparam int VALID_W          = 19;
    localparam int SLOT_W           = 4;
    localparam int KIDX_W           = 3;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = 2;
    localparam int QCNT_W           = 3;
    localparam int MEMORY_WORDS_DEF = 262144;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 40;
    localparam int OUT_TDATA_W      = 72;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_WORDS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LIMIT = 1'b1;

    // One rebuilt capture word on its way from front to back
    typedef struct packed {
        logic              clr;   // first word of a slice that began a capture
        logic              eos;   // last capture word of its slice
        logic [WORD_W-1:0] word;
    } qentry_t;

endpackage

### hw/rtl/prcd_front.sv
`timescale 1ns / 1ps
// Front end: buffers eight transfer words, merges the nibble word and
// pushes rebuilt 36-bit capture words into the queue. Uses prcd_pkg.
module prcd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [prcd_pkg::XFER_W-1:0]   s_word,
    input  logic                          s_start,
    output logic                          q_push,
    output prcd_pkg::qentry_t             q_entry,
    input  logic                          q_full
);

    typedef enum logic {F_FILL, F_UNLOAD} fstate_t;

    fstate_t                         state_reg, state_next;
    logic [prcd_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [prcd_pkg::KIDX_W-1:0]     k_reg, k_next;
    logic                            flag_reg, flag_next;
    logic [prcd_pkg::XFER_W-1:0]     nibble_reg, nibble_next;
    logic [prcd_pkg::XFER_W-1:0]     buf_reg [prcd_pkg::SLICE_WORDS];

    logic                            accept;
    logic [prcd_pkg::SLOT_W-1:0]     eff_slot;
    logic                            is_nibble;
    logic [prcd_pkg::KIDX_W-1:0]     nib_idx;

    assign s_tready  = (state_reg == F_FILL);
    assign accept    = s_tvalid && s_tready;
    // a start of capture always lands the word in slot 0
    assign eff_slot  = s_start ? '0 : slot_reg;
    assign is_nibble = (eff_slot == prcd_pkg::SLOT_W'(prcd_pkg::SLICE_WORDS));
    // word k takes nibble 7-k of the ninth word
    assign nib_idx   = ~k_reg;

    assign q_push        = (state_reg == F_UNLOAD) && !q_full;
    assign q_entry.word  = {nibble_reg[{nib_idx, 2'b00} +: 4], buf_reg[k_reg]};
    assign q_entry.clr   = flag_reg && (k_reg == '0);
    assign q_entry.eos   = (k_reg == prcd_pkg::KIDX_W'(prcd_pkg::SLICE_WORDS - 1));

    always_comb begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        k_next      = k_reg;
        flag_next   = flag_reg;
        nibble_next = nibble_reg;
        case (state_reg)
            F_FILL: begin
                if (accept) begin
                    if (is_nibble) begin
                        nibble_next = s_word;
                        slot_next   = '0;
                        k_next      = '0;
                        state_next  = F_UNLOAD;
                    end else begin
                        slot_next = eff_slot + prcd_pkg::SLOT_W'(1);
                        if (eff_slot == '0) begin
                            flag_next = s_start;
                        end
                    end
                end
            end
            F_UNLOAD: begin
                if (q_push) begin
                    k_next = k_reg + prcd_pkg::KIDX_W'(1);
                    if (q_entry.eos) begin
                        state_next = F_FILL;
                    end
                end
            end
            default: state_next = F_FILL;
        endcase
    end

    always_ff @(posedge aclk) begin
        nibble_reg <= nibble_next;
        k_reg      <= k_next;
        flag_reg   <= flag_next;
        if (accept && !is_nibble) begin
            buf_reg[eff_slot[prcd_pkg::KIDX_W-1:0]] <= s_word;
        end
        if (!aresetn) begin
            state_reg <= F_FILL;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

### hw/rtl/prcd_queue.sv
`timescale 1ns / 1ps
// Short FIFO of capture words between the front and back ends.
// Uses prcd_pkg for the entry type and depth.
module prcd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  prcd_pkg::qentry_t wr_entry,
    output logic              full,
    input  logic              pop,
    output prcd_pkg::qentry_t rd_entry,
    output logic              not_empty
);

    prcd_pkg::qentry_t               mem_reg [prcd_pkg::QUEUE_DEPTH];
    logic [prcd_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [prcd_pkg::QCNT_W-1:0]     cnt_reg;
    logic                            do_push, do_pop;

    assign full      = (cnt_reg == prcd_pkg::QCNT_W'(prcd_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_entry  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + prcd_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + prcd_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + prcd_pkg::QCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - prcd_pkg::QCNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

### hw/rtl/prcd_back.sv
`timescale 1ns / 1ps
// Back end: decodes capture words into runs, clips them to the sample
// limit and drives the result register. Uses prcd_pkg.
module prcd_back #(
    parameter int MEMORY_WORDS = prcd_pkg::MEMORY_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  prcd_pkg::qentry_t              q_entry,
    output logic                           q_pop,
    input  logic [prcd_pkg::VALID_W-1:0]   valid_words,
    input  logic [prcd_pkg::LIMIT_W-1:0]   sample_limit,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [prcd_pkg::NUM_CH-1:0]    m_sample,
    output logic [prcd_pkg::RUN_W-1:0]     m_count,
    output logic                           m_hit,
    output logic                           m_last
);

    localparam int WD_W  = $clog2(MEMORY_WORDS + 1);
    localparam int CMP_W = (WD_W > prcd_pkg::VALID_W) ? WD_W : prcd_pkg::VALID_W;
    localparam logic [CMP_W-1:0] MEM_STOP = CMP_W'(MEMORY_WORDS);

    typedef enum logic [1:0] {B_DECODE, B_EMIT, B_FLUSH} bstate_t;

    bstate_t                          state_reg, state_next;
    logic                             expect_reg, expect_next;
    logic [WD_W-1:0]                  words_reg, words_next;
    logic [prcd_pkg::LIMIT_W-1:0]     samples_reg, samples_next;
    logic                             finished_reg, finished_next;
    logic [prcd_pkg::NUM_CH-1:0]      sample_reg, sample_next;
    logic [prcd_pkg::RUN_W-1:0]       run_reg, run_next;
    logic [prcd_pkg::LIMIT_W-1:0]     remain_reg, remain_next;
    logic                             eos_reg, eos_next;
    // held result: its last flag is known only once the slice is done
    logic                             hold_valid_reg, hold_valid_next;
    logic [prcd_pkg::NUM_CH-1:0]      hold_sample_reg, hold_sample_next;
    logic [prcd_pkg::RUN_W-1:0]       hold_count_reg, hold_count_next;
    logic                             hold_hit_reg, hold_hit_next;
    logic                             out_valid_reg, out_valid_next;
    logic [prcd_pkg::NUM_CH-1:0]      out_sample_reg, out_sample_next;
    logic [prcd_pkg::RUN_W-1:0]       out_count_reg, out_count_next;
    logic                             out_hit_reg, out_hit_next;
    logic                             out_last_reg, out_last_next;

    logic                             clr;
    logic                             eff_expect, eff_finished;
    logic [WD_W-1:0]                  eff_words;
    logic [prcd_pkg::LIMIT_W-1:0]     eff_samples;
    logic [CMP_W-1:0]                 vw_ext, stop, words_ext;
    logic                             past_stop, at_limit;
    logic                             out_free;
    logic                             hit;
    logic [prcd_pkg::RUN_W-1:0]       count;
    logic [prcd_pkg::WORD_W-1:0]      w;

    assign q_pop       = (state_reg == B_DECODE) && q_valid;
    assign w           = q_entry.word;
    assign clr         = q_pop && q_entry.clr;
    assign eff_expect  = clr ? 1'b0 : expect_reg;
    assign eff_words   = clr ? '0 : words_reg;
    assign eff_samples = clr ? '0 : samples_reg;
    assign eff_finished = clr ? 1'b0 : finished_reg;
    assign vw_ext      = CMP_W'(valid_words);
    assign stop        = (vw_ext < MEM_STOP) ? vw_ext : MEM_STOP;
    assign words_ext   = CMP_W'(eff_words);
    assign past_stop   = eff_finished || (words_ext >= stop);
    assign at_limit    = (eff_samples >= sample_limit);
    assign out_free    = !out_valid_reg || m_tready;

    // remaining is at least one here, so a clipped count fits the run width
    assign hit   = ({2'b00, run_reg} >= remain_reg);
    assign count = hit ? remain_reg[prcd_pkg::RUN_W-1:0] : run_reg;

    assign m_tvalid = out_valid_reg;
    assign m_sample = out_sample_reg;
    assign m_count  = out_count_reg;
    assign m_hit    = out_hit_reg;
    assign m_last   = out_last_reg;

    always_comb begin
        state_next       = state_reg;
        expect_next      = expect_reg;
        words_next       = words_reg;
        samples_next     = samples_reg;
        finished_next    = finished_reg;
        sample_next      = sample_reg;
        run_next         = run_reg;
        remain_next      = remain_reg;
        eos_next         = eos_reg;
        hold_valid_next  = hold_valid_reg;
        hold_sample_next = hold_sample_reg;
        hold_count_next  = hold_count_reg;
        hold_hit_next    = hold_hit_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_sample_next  = out_sample_reg;
        out_count_next   = out_count_reg;
        out_hit_next     = out_hit_reg;
        out_last_next    = out_last_reg;
        case (state_reg)
            B_DECODE: begin
                if (q_pop) begin
                    expect_next   = eff_expect;
                    words_next    = eff_words;
                    samples_next  = eff_samples;
                    finished_next = eff_finished;
                    remain_next   = sample_limit - eff_samples;
                    eos_next      = q_entry.eos;
                    state_next    = q_entry.eos ? B_FLUSH : B_DECODE;
                    if (!past_stop) begin
                        if (at_limit) begin
                            finished_next = 1'b1;
                        end else begin
                            words_next = eff_words + WD_W'(1);
                            if (!eff_expect) begin
                                sample_next = w[prcd_pkg::NUM_CH-1:0];
                                run_next    = {37'd0, w[prcd_pkg::NUM_CH]} + 38'd1;
                                if (w[prcd_pkg::WORD_W-1]) begin
                                    expect_next = 1'b1;
                                end else begin
                                    state_next = B_EMIT;
                                end
                            end else begin
                                run_next    = run_reg + {1'b0, w, 1'b0};
                                expect_next = 1'b0;
                                state_next  = B_EMIT;
                            end
                        end
                    end
                end
            end
            B_EMIT: begin
                if (!hold_valid_reg || out_free) begin
                    if (hold_valid_reg) begin
                        out_valid_next  = 1'b1;
                        out_sample_next = hold_sample_reg;
                        out_count_next  = hold_count_reg;
                        out_hit_next    = hold_hit_reg;
                        out_last_next   = 1'b0;
                    end
                    hold_valid_next  = 1'b1;
                    hold_sample_next = sample_reg;
                    hold_count_next  = count;
                    hold_hit_next    = hit;
                    samples_next     = hit ? sample_limit
                                           : samples_reg + prcd_pkg::LIMIT_W'(run_reg);
                    run_next         = '0;
                    finished_next    = finished_reg || hit;
                    state_next       = eos_reg ? B_FLUSH : B_DECODE;
                end
            end
            B_FLUSH: begin
                if (!hold_valid_reg) begin
                    state_next = B_DECODE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = hold_sample_reg;
                    out_count_next  = hold_count_reg;
                    out_hit_next    = hold_hit_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = B_DECODE;
                end
            end
            default: state_next = B_DECODE;
        endcase
    end

    always_ff @(posedge aclk) begin
        sample_reg      <= sample_next;
        run_reg         <= run_next;
        remain_reg      <= remain_next;
        eos_reg         <= eos_next;
        hold_sample_reg <= hold_sample_next;
        hold_count_reg  <= hold_count_next;
        hold_hit_reg    <= hold_hit_next;
        out_sample_reg  <= out_sample_next;
        out_count_reg   <= out_count_next;
        out_hit_reg     <= out_hit_next;
        out_last_reg    <= out_last_next;
        if (!aresetn) begin
            state_reg      <= B_DECODE;
            expect_reg     <= 1'b0;
            words_reg      <= '0;
            samples_reg    <= '0;
            finished_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            expect_reg     <= expect_next;
            words_reg      <= words_next;
            samples_reg    <= samples_next;
            finished_reg   <= finished_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

### hw/rtl/packed_rle_capture_decoder.sv
`timescale 1ns / 1ps
// Top level of the packed run-length capture decoder: configuration
// registers and the front end / queue / back end. Uses prcd_pkg.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata transfer word, s_tuser start
//  m_        out  m_tvalid/m_tready  m_tdata sample+count, m_tuser limit,
//                                    m_tlast last run of the slice
//  cfg_      in   cfg_we             cfg_addr register index, cfg_wdata
//
// Flow: a slice of nine transfer words is taken in at the input: nine
//   accepts, then the eight rebuilt words are moved into the queue while
//   s_tready is low. The back end spends a decode step on each capture
//   word, an emit step on each run and a flush step on each slice to
//   release the last run; emit and flush wait while the result is stalled.
// Reset: aresetn is synchronous and active low; it clears control state,
//   sets valid_words to 0 and sample_limit to all ones.
// Stalls: the queue decouples the halves, and the result register holds a
//   transaction while m_tready is low without blocking decoding of the
//   next run into the hold stage.
module packed_rle_capture_decoder #(
    parameter int MEMORY_WORDS = prcd_pkg::MEMORY_WORDS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // fields from bit 0: transfer_word[31:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [prcd_pkg::XFER_W-1:0]         s_tdata,
    // fields from bit 0: start_capture
    input  logic [0:0]                          s_tuser,
    // fields from bit 0: sample_value[33:0], run_count[71:34]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [prcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // fields from bit 0: limit_reached
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [prcd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [prcd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [prcd_pkg::VALID_W-1:0]   valid_words_reg;
    logic [prcd_pkg::LIMIT_W-1:0]   sample_limit_reg;

    logic                           q_push, q_full, q_pop, q_valid;
    prcd_pkg::qentry_t              q_wr, q_rd;
    logic [prcd_pkg::NUM_CH-1:0]    res_sample;
    logic [prcd_pkg::RUN_W-1:0]     res_count;
    logic                           res_hit;

    // configuration registers; write only while the block is idle (not enforced by the block)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_words_reg  <= '0;
            sample_limit_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_addr)
                prcd_pkg::CFG_VALID_WORDS:
                    valid_words_reg <= cfg_wdata[prcd_pkg::VALID_W-1:0];
                prcd_pkg::CFG_SAMPLE_LIMIT:
                    sample_limit_reg <= cfg_wdata[prcd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    prcd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_word   (s_tdata),
        .s_start  (s_tuser[0]),
        .q_push   (q_push),
        .q_entry  (q_wr),
        .q_full   (q_full)
    );

    prcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wr_entry  (q_wr),
        .full      (q_full),
        .pop       (q_pop),
        .rd_entry  (q_rd),
        .not_empty (q_valid)
    );

    prcd_back #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_entry      (q_rd),
        .q_pop        (q_pop),
        .valid_words  (valid_words_reg),
        .sample_limit (sample_limit_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_sample     (res_sample),
        .m_count      (res_count),
        .m_hit        (res_hit),
        .m_last       (m_tlast)
    );

    assign m_tdata    = {res_count, res_sample};
    assign m_tuser[0] = res_hit;

endmodule

### hw/rtl/prcd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the packed run-length capture decoder, bound to
// the top level. Uses prcd_pkg for widths.
module prcd_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [prcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic [0:0]                          m_tuser,
    input  logic                                m_tlast
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // once the limit is reached the rest of the slice is dropped
    a_hit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("limit run not marked last");

    // a run always covers at least one sample
    a_count_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[prcd_pkg::OUT_TDATA_W-1:prcd_pkg::NUM_CH] != '0)
        else $error("empty run emitted");

endmodule

bind packed_rle_capture_decoder prcd_checker u_prcd_checker (.*);
